/* rtl/m4vt_pkg.sv */
// m4vt_pkg: shared constants, types and helpers for the 4x4 matrix-vector transform.
// No dependencies; compiled first.
`default_nettype none

package m4vt_pkg;

  localparam int FRAC_BITS  = 16;  // fraction bits of the fixed-point format, 8..24
  localparam int ELEM_WIDTH = 32;  // stored element and saturation width, 16..48
  localparam int FIELD_W    = 32;  // width of every vector and result field
  localparam int MAT_DIM    = 4;
  localparam int IDX_W      = $clog2(MAT_DIM);

  localparam int PROD_W = ELEM_WIDTH + FIELD_W;
  localparam int SUM_W  = PROD_W + $clog2(MAT_DIM);
  localparam int SH_W   = SUM_W - FRAC_BITS;

  // fourth vector component in point mode: exactly one
  localparam logic [FIELD_W-1:0] W_ONE = FIELD_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_POINT = 2'd1,
    FUNC_DIR   = 2'd2,
    FUNC_FULL  = 2'd3
  } func_e;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [FIELD_W-1:0]    field_t;

  typedef struct packed {
    logic load_prod;  // capture the four products
    logic load_sum;   // capture the reduced, saturated component
  } lane_ctrl_t;

  typedef struct packed {
    field_t data;
    logic   clip;
  } lane_res_t;

  // field value to element width (sign-extend or keep low bits)
  function automatic elem_t field_to_elem(input field_t v);
    logic signed [63:0] wide;
    wide = 64'(v);
    return wide[ELEM_WIDTH-1:0];
  endfunction

  // element value to field width (sign-extend or keep low bits)
  function automatic field_t elem_to_field(input elem_t v);
    logic signed [63:0] wide;
    wide = 64'(v);
    return wide[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/m4vt_if.sv */
// m4vt_in_if / m4vt_out_if: valid/ready channels for input and result beats.
// Depends on m4vt_pkg.
`default_nettype none

interface m4vt_in_if;
  import m4vt_pkg::*;

  logic   valid;
  logic   ready;
  logic [1:0] func;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  field_t elem_value;
  field_t vec_x;
  field_t vec_y;
  field_t vec_z;
  field_t vec_w;

  modport source (
    output valid, func, row, col, elem_value, vec_x, vec_y, vec_z, vec_w,
    input  ready
  );
  modport sink (
    input  valid, func, row, col, elem_value, vec_x, vec_y, vec_z, vec_w,
    output ready
  );
endinterface

interface m4vt_out_if;
  import m4vt_pkg::*;

  logic   valid;
  logic   ready;
  field_t out_x;
  field_t out_y;
  field_t out_z;
  field_t out_w;
  logic   saturated;

  modport source (
    output valid, out_x, out_y, out_z, out_w, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w, saturated,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/matrix4_vector_transform_unit.sv */
// matrix4_vector_transform_unit: 4x4 fixed-point matrix times vector, top level.
// Depends on m4vt_pkg, m4vt_if (m4vt_in_if, m4vt_out_if) and m4vt_lane.
//
// The unit holds a 4x4 matrix of signed Q15.16 elements (all zero after reset)
// and takes one beat per clock while in_i.ready is high. A write beat
// (func = write) stores elem_value at row/col and gives no result; the very next
// beat already sees the new element. A transform beat (point, direction or full)
// gives one result beat: four row lanes each form their four products in the first
// register stage, sum, floor-shift and saturate in the second, and the merge
// stage registers the four components together with the OR of the clip flags
// as "saturated". The three stages have their own valid bits and stall
// independently, so bubbles fill up behind a stalled result and in_i.ready
// only drops once all three hold a result.
`default_nettype none

module matrix4_vector_transform_unit (
  input  wire               clk_i,
  input  wire               rst_ni,
  m4vt_in_if.sink           in_i,
  m4vt_out_if.source        out_o
);
  import m4vt_pkg::*;

  // matrix storage, row-major; each lane reads its own row
  elem_t       mat_q [MAT_DIM][MAT_DIM];

  field_t      vec_sel [MAT_DIM];
  lane_ctrl_t  lane_ctrl;
  lane_res_t   lane_res [MAT_DIM];

  logic        in_acc;
  logic        is_write;
  logic        v1_q, v2_q, ov_q;
  logic        rdy1, rdy2, rdy3;

  field_t      out_x_q, out_y_q, out_z_q, out_w_q;
  logic        sat_q;

  // ---- stage handshake: each stage moves when empty or downstream moves ----
  assign rdy3 = !ov_q || out_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_i.ready = rdy1;
  assign in_acc     = in_i.valid && rdy1;
  assign is_write   = (in_i.func == FUNC_WRITE);

  assign lane_ctrl.load_prod = rdy1;
  assign lane_ctrl.load_sum  = rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_acc && !is_write;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        ov_q <= v2_q;
      end
    end
  end

  // ---- element write ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAT_DIM; r++) begin
        for (int c = 0; c < MAT_DIM; c++) begin
          mat_q[r][c] <= '0;
        end
      end
    end else if (in_acc && is_write) begin
      mat_q[in_i.row][in_i.col] <= field_to_elem(in_i.elem_value);
    end
  end

  // ---- vector operand: fourth component by mode ----
  always_comb begin
    vec_sel[0] = in_i.vec_x;
    vec_sel[1] = in_i.vec_y;
    vec_sel[2] = in_i.vec_z;
    case (in_i.func)
      FUNC_POINT: vec_sel[3] = W_ONE;
      FUNC_FULL:  vec_sel[3] = in_i.vec_w;
      default:    vec_sel[3] = '0;
    endcase
  end

  // ---- row lanes ----
  for (genvar g = 0; g < MAT_DIM; g++) begin : g_lane
    m4vt_lane u_lane (
      .clk_i  (clk_i),
      .elem_i (mat_q[g]),
      .vec_i  (vec_sel),
      .ctrl_i (lane_ctrl),
      .res_o  (lane_res[g])
    );
  end

  // ---- merge stage: output register ----
  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      out_x_q <= lane_res[0].data;
      out_y_q <= lane_res[1].data;
      out_z_q <= lane_res[2].data;
      out_w_q <= lane_res[3].data;
      sat_q   <= lane_res[0].clip | lane_res[1].clip | lane_res[2].clip | lane_res[3].clip;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_x     = out_x_q;
  assign out_o.out_y     = out_y_q;
  assign out_o.out_z     = out_z_q;
  assign out_o.out_w     = out_w_q;
  assign out_o.saturated = sat_q;

`ifndef NO_ASSERTIONS
  // a write beat never enters the product stage
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_write) |=> !v1_q)
    else $error("write beat produced a pipeline entry");

  // a transform beat always enters the product stage
  a_xform_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_write) |=> v1_q)
    else $error("transform beat lost at the product stage");

  // the addressed element holds the written value on the next cycle
  a_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_write) |=>
      (mat_q[$past(in_i.row)][$past(in_i.col)] == field_to_elem($past(in_i.elem_value))))
    else $error("matrix element write not stored");

  // a stalled product stage keeps its entry
  a_stage1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |=> v1_q)
    else $error("product stage dropped a beat under stall");
`endif

endmodule

`default_nettype wire

/* rtl/m4vt_lane.sv */
// m4vt_lane: one matrix row times the vector; four registered products, then
// a registered sum, floor shift and saturation. Depends on m4vt_pkg.
`default_nettype none

module m4vt_lane (
  input  wire                      clk_i,
  input  m4vt_pkg::elem_t          elem_i [m4vt_pkg::MAT_DIM],
  input  m4vt_pkg::field_t         vec_i  [m4vt_pkg::MAT_DIM],
  input  m4vt_pkg::lane_ctrl_t     ctrl_i,
  output m4vt_pkg::lane_res_t      res_o
);
  import m4vt_pkg::*;

  logic signed [PROD_W-1:0] prod_q [MAT_DIM];
  logic signed [PROD_W-1:0] prod_d [MAT_DIM];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SH_W-1:0]   shifted;
  logic [SH_W-ELEM_WIDTH:0] upper;
  elem_t                    sat_val;
  lane_res_t                res_d;
  lane_res_t                res_q;

  always_comb begin
    for (int k = 0; k < MAT_DIM; k++) begin
      prod_d[k] = PROD_W'(elem_i[k]) * PROD_W'(vec_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_prod) begin
      prod_q <= prod_d;
    end
  end

  // exact sum, floor by dropping fraction bits, clip to element range
  always_comb begin
    sum = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]) + SUM_W'(prod_q[3]);
    shifted = sum[SUM_W-1:FRAC_BITS];
    upper   = shifted[SH_W-1:ELEM_WIDTH-1];
    if ((&upper) || !(|upper)) begin
      sat_val    = shifted[ELEM_WIDTH-1:0];
      res_d.clip = 1'b0;
    end else begin
      sat_val    = shifted[SH_W-1] ? {1'b1, {(ELEM_WIDTH-1){1'b0}}}
                                   : {1'b0, {(ELEM_WIDTH-1){1'b1}}};
      res_d.clip = 1'b1;
    end
    res_d.data = elem_to_field(sat_val);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_sum) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* tb/sv/tb_matrix4_vector_transform_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for matrix4_vector_transform_unit: directed and random beats,
// with an in-order predictor of the 4x4 fixed-point transform.
// Depends on m4vt_pkg, m4vt_in_if / m4vt_out_if and the unit itself.

module tb_matrix4_vector_transform_unit;
  import m4vt_pkg::*;

  // Accumulator wide enough for the exact sum of four products.
  localparam int ACC_W = ELEM_WIDTH + FIELD_W + 2;
  localparam logic signed [ACC_W-1:0] CLIP_HI =
    {{(ACC_W-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] CLIP_LO = ~CLIP_HI;

  localparam field_t Q_ONE = field_t'(1) << FRAC_BITS;
  localparam field_t F_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam field_t F_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  localparam int RANDOM_BEATS = 1830;
  localparam int CALM_TAIL    = 150;  // last beats go without any idling
  localparam int HOLD_AT      = 700;  // input beats accepted before the long hold
  localparam int HOLD_LEN     = 120;
  localparam int DRAIN_AT     = 1000;
  localparam int TAIL_CYCLES  = 20;   // idle clocks run after all results are in
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    func_e      func;
    logic [1:0] row;
    logic [1:0] col;
    field_t     elem;
    field_t     x, y, z, w;
    bit         drain;  // hold this beat back until all results are in
  } cmd_t;

  typedef struct {
    field_t x, y, z, w;
    logic   sat;
  } xform_t;

  logic clk_i;
  logic rst_ni;

  m4vt_in_if  in_bus ();
  m4vt_out_if out_bus ();

  matrix4_vector_transform_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  cmd_t   cmd_q[$];    // beats waiting to be offered
  xform_t xform_q[$];  // transform results still owed by the unit
  elem_t  mat[4][4];   // predicted matrix contents

  int  mismatches  = 0;
  int  beats_in    = 0;
  int  results_in  = 0;
  int  cycles      = 0;
  int  send_gap    = 0;
  int  recv_gap    = 0;
  int  hold_cnt    = 0;
  bit  hold_done   = 1'b0;
  bit  long_hold   = 1'b0;
  bit  in_took     = 1'b0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Matrix times column vector; each lane floored by the fraction shift and
  // clipped to the element range, only the low field bits are returned.
  function automatic xform_t transform_vector(input cmd_t c);
    field_t                  v[4];
    field_t                  lane[4];
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] m_ext;
    logic signed [ACC_W-1:0] v_ext;
    logic signed [ACC_W-1:0] shifted;
    xform_t                  r;
    v[0] = c.x;
    v[1] = c.y;
    v[2] = c.z;
    case (c.func)
      FUNC_POINT: v[3] = Q_ONE;
      FUNC_DIR:   v[3] = '0;
      default:    v[3] = c.w;
    endcase
    r.sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      acc = '0;
      for (int j = 0; j < 4; j++) begin
        m_ext = mat[i][j];
        v_ext = v[j];
        acc = acc + m_ext * v_ext;
      end
      shifted = acc >>> FRAC_BITS;
      if (shifted > CLIP_HI) begin
        shifted = CLIP_HI;
        r.sat = 1'b1;
      end else if (shifted < CLIP_LO) begin
        shifted = CLIP_LO;
        r.sat = 1'b1;
      end
      lane[i] = shifted[FIELD_W-1:0];
    end
    r.x = lane[0];
    r.y = lane[1];
    r.z = lane[2];
    r.w = lane[3];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Q15.16 operand: mostly modest magnitudes, plus raw words and corner values.
  function automatic field_t pick_q16();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35)
      return field_t'($urandom_range(0, 16 << FRAC_BITS)) - (field_t'(8) << FRAC_BITS);
    else if (r < 65)
      return field_t'($urandom());
    else if (r < 80) begin
      case ($urandom_range(6))
        0:       return F_MAX;
        1:       return F_MIN;
        2:       return '0;
        3:       return Q_ONE;
        4:       return -Q_ONE;
        5:       return -1;
        default: return 1;
      endcase
    end
    return field_t'($urandom_range(0, 1 << 25)) - (field_t'(1) << 24);
  endfunction

  task automatic add_write(input logic [1:0] r, input logic [1:0] c, input field_t v);
    cmd_t b;
    b.func  = FUNC_WRITE;
    b.row   = r;
    b.col   = c;
    b.elem  = v;
    // vector fields are don't-care on a write
    b.x     = $urandom();
    b.y     = $urandom();
    b.z     = $urandom();
    b.w     = $urandom();
    b.drain = 1'b0;
    cmd_q.push_back(b);
  endtask

  task automatic add_xform(input func_e f, input field_t x, input field_t y,
                           input field_t z, input field_t w);
    cmd_t b;
    b.func  = f;
    // element address and value are don't-care on a transform
    b.row   = 2'($urandom_range(3));
    b.col   = 2'($urandom_range(3));
    b.elem  = $urandom();
    b.x     = x;
    b.y     = y;
    b.z     = z;
    b.w     = w;
    b.drain = 1'b0;
    cmd_q.push_back(b);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH result %0d %s: got %h expected %h", results_in, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued beats, idles in random bursts, honors drain marks
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    cmd_t nxt;
    int   idle_pct;
    if (rst_ni && (!in_bus.valid || in_took)) begin
      case ((beats_in / 150) % 3)
        0:       idle_pct = 0;   // stretch with no idling at all
        1:       idle_pct = 12;
        default: idle_pct = 35;
      endcase
      if (in_took && cmd_q.size() >= CALM_TAIL && $urandom_range(99) < idle_pct)
        send_gap = $urandom_range(1, 14);
      if (send_gap > 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (cmd_q.size() == 0 || (cmd_q[0].drain && xform_q.size() != 0)) begin
        in_bus.valid <= 1'b0;
      end else begin
        nxt = cmd_q.pop_front();
        in_bus.func       <= nxt.func;
        in_bus.row        <= nxt.row;
        in_bus.col        <= nxt.col;
        in_bus.elem_value <= nxt.elem;
        in_bus.vec_x      <= nxt.x;
        in_bus.vec_y      <= nxt.y;
        in_bus.vec_z      <= nxt.z;
        in_bus.vec_w      <= nxt.w;
        in_bus.valid      <= 1'b1;
      end
    end
  end

  // Input side: every accepted beat updates the predicted matrix or queues
  // the result it owes.
  always @(posedge clk_i) begin
    cmd_t got;
    in_took <= rst_ni && in_bus.valid && in_bus.ready;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      got.func  = func_e'(in_bus.func);
      got.row   = in_bus.row;
      got.col   = in_bus.col;
      got.elem  = in_bus.elem_value;
      got.x     = in_bus.vec_x;
      got.y     = in_bus.vec_y;
      got.z     = in_bus.vec_z;
      got.w     = in_bus.vec_w;
      got.drain = 1'b0;
      beats_in++;
      if (got.func == FUNC_WRITE)
        mat[got.row][got.col] = got.elem;  // sign-extends or trims to element width
      else
        xform_q.push_back(transform_vector(got));
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts plus one long hold so the pipe backs up
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
    end else if (!hold_done && beats_in >= HOLD_AT) begin
      hold_cnt  = HOLD_LEN;
      hold_done = 1'b1;
    end
    long_hold <= (hold_cnt > 0);
  end

  always @(negedge clk_i) begin
    int stall_pct;
    case ((results_in / 100) % 3)
      0:       stall_pct = 0;
      1:       stall_pct = 15;
      default: stall_pct = 40;
    endcase
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_bus.ready <= 1'b0;
    end else if (long_hold) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      if (cmd_q.size() >= CALM_TAIL && $urandom_range(99) < stall_pct)
        recv_gap = $urandom_range(1, 14);
    end
  end

  // Output side: compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    xform_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (xform_q.size() == 0) begin
        report_mismatch("beat with nothing expected, out_x", out_bus.out_x, '0);
      end else begin
        want = xform_q.pop_front();
        if (out_bus.out_x !== want.x) report_mismatch("out_x", out_bus.out_x, want.x);
        if (out_bus.out_y !== want.y) report_mismatch("out_y", out_bus.out_y, want.y);
        if (out_bus.out_z !== want.z) report_mismatch("out_z", out_bus.out_z, want.z);
        if (out_bus.out_w !== want.w) report_mismatch("out_w", out_bus.out_w, want.w);
        if (out_bus.saturated !== want.sat)
          report_mismatch("saturated", 32'(out_bus.saturated), 32'(want.sat));
      end
      results_in++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed beats, random beats, drain, verdict
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned r;
    in_bus.valid      = 1'b0;
    in_bus.func       = FUNC_WRITE;
    in_bus.row        = '0;
    in_bus.col        = '0;
    in_bus.elem_value = '0;
    in_bus.vec_x      = '0;
    in_bus.vec_y      = '0;
    in_bus.vec_z      = '0;
    in_bus.vec_w      = '0;
    out_bus.ready     = 1'b0;
    rst_ni            = 1'b0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        mat[i][j] = '0;

    // Directed: zero matrix first, so any transform must come back zero.
    add_xform(FUNC_FULL, F_MAX, F_MIN, F_MAX, F_MIN);
    add_xform(FUNC_POINT, -1, -1, -1, -1);
    // Load corner elements; vector fields ride along and must be ignored.
    add_write(2'd0, 2'd0, F_MAX);
    add_write(2'd0, 2'd1, F_MIN);
    add_write(2'd0, 2'd3, Q_ONE);
    add_write(2'd1, 2'd1, Q_ONE);
    add_write(2'd1, 2'd3, -(Q_ONE >>> 1));
    add_write(2'd2, 2'd0, -1);
    add_write(2'd2, 2'd2, Q_ONE);
    add_write(2'd3, 2'd2, 1);
    add_write(2'd3, 2'd3, F_MIN);
    // Point, direction and full modes; positive and negative clipping,
    // floor rounding of tiny negatives, w at both extremes.
    add_xform(FUNC_POINT, Q_ONE, Q_ONE <<< 1, -(Q_ONE * 3), F_MAX);
    add_xform(FUNC_POINT, F_MAX, '0, '0, F_MIN);
    add_xform(FUNC_DIR, F_MIN, F_MAX, '0, F_MAX);
    add_xform(FUNC_DIR, 1, '0, '0, F_MIN);
    add_xform(FUNC_FULL, '0, '0, '0, F_MAX);
    add_xform(FUNC_FULL, '0, '0, '0, F_MIN);
    add_xform(FUNC_FULL, F_MAX, F_MAX, F_MAX, F_MAX);
    add_xform(FUNC_FULL, F_MIN, F_MIN, F_MIN, F_MIN);
    // Overwrite an element and use it right away.
    add_write(2'd0, 2'd0, '0);
    add_xform(FUNC_POINT, Q_ONE, -Q_ONE, Q_ONE, '0);

    // Random: one write in five, transforms spread over the three modes.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      r = $urandom_range(99);
      if (r < 20)
        add_write(2'($urandom_range(3)), 2'($urandom_range(3)), pick_q16());
      else if (r < 47)
        add_xform(FUNC_POINT, pick_q16(), pick_q16(), pick_q16(), pick_q16());
      else if (r < 73)
        add_xform(FUNC_DIR, pick_q16(), pick_q16(), pick_q16(), pick_q16());
      else
        add_xform(FUNC_FULL, pick_q16(), pick_q16(), pick_q16(), pick_q16());
      // sender waits for an empty pipe here and right after the directed part
      if (n == 0 || n == DRAIN_AT)
        cmd_q[$].drain = 1'b1;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || in_bus.valid || xform_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/m4vt_pkg.sv
rtl/m4vt_if.sv
rtl/m4vt_lane.sv
rtl/matrix4_vector_transform_unit.sv
tb/sv/tb_matrix4_vector_transform_unit.sv
